FILE: src/coct_pkg.sv
package coct_pkg;

	// Width and reset value of the robot diameter register.
	localparam int unsigned DIAM_W = 12;
	localparam logic [DIAM_W-1:0] DIAM_RESET = 12'd20;

	// Operation codes carried by an input beat.
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_DEL = 2'd1;
	localparam logic [1:0] OP_CHK = 2'd2;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_ADD,
		S_READ,
		S_EVAL,
		S_TEST,
		S_SQX,
		S_SQY,
		S_CMPSQ,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_DONE
	} state_t;

endpackage

FILE: src/circle_obstacle_collision_table.sv
// Channel   Handshake                Beat contents
// input     in_valid / in_stall      opcode, pos_x, pos_y, rect_width, rect_height
// output    out_valid / out_stall    success, table_full, obstacle_count
// config    cfg_valid / cfg_ready    cfg_diameter
//
// One item is worked at a time by a sequencer around one table memory port and one
// shared multiplier. A check visits the obstacles in order and squares the corner
// distance only when neither the bounding box nor a straight side settles it. A delete
// scans the entries and moves the later entries down during compaction.
// Reset clears the count and the control state; the table memory is not cleared.
// A finished result waits in the output register while the next beat is accepted.
module circle_obstacle_collision_table #(
	parameter int unsigned MAX_OBSTACLES = 64,
	parameter int unsigned COORD_BITS = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             opcode,
	input  logic [COORD_BITS-1:0]                  pos_x,
	input  logic [COORD_BITS-1:0]                  pos_y,
	input  logic [COORD_BITS-1:0]                  rect_width,
	input  logic [COORD_BITS-1:0]                  rect_height,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   success,
	output logic                                   table_full,
	output logic [$clog2(MAX_OBSTACLES+1)-1:0]     obstacle_count,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [coct_pkg::DIAM_W-1:0]            cfg_diameter
);
	import coct_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_OBSTACLES + 1);
	localparam int unsigned IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int unsigned ENT_W = 4 * COORD_BITS;
	localparam int unsigned AW = ((COORD_BITS > DIAM_W) ? COORD_BITS : DIAM_W) + 1;
	localparam int unsigned RAD_W = DIAM_W - 1;
	localparam int unsigned MUL_W = (COORD_BITS > RAD_W) ? COORD_BITS : RAD_W;
	localparam int unsigned PROD_W = 2 * MUL_W;
	localparam int unsigned SUM_W = PROD_W + 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OBSTACLES);

	state_t state_q, state_d;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] i_q;
	logic [1:0] op_q;
	logic [COORD_BITS-1:0] x_q, y_q, w_q, h_q;
	logic [DIAM_W-1:0] diam_q;
	logic [COORD_BITS-1:0] dx_q, dy_q, ex_q, ey_q;
	logic [PROD_W-1:0] acc_q, radsq_q;
	logic [SUM_W-1:0] sum_q;
	logic ok_q, full_q;
	logic out_valid_q, success_q, table_full_q;
	logic [CNT_W-1:0] obstacle_count_q;

	// Table memory with registered read data.
	logic [ENT_W-1:0] mem_q [MAX_OBSTACLES];
	logic [ENT_W-1:0] rd_data_q;
	logic mem_we, mem_re;
	logic [IDX_W-1:0] mem_wa, mem_ra;
	logic [ENT_W-1:0] mem_wd;

	// Fields of the entry just read.
	logic [COORD_BITS-1:0] e_cx, e_cy, e_w, e_h;
	assign e_cx = rd_data_q[4*COORD_BITS-1:3*COORD_BITS];
	assign e_cy = rd_data_q[3*COORD_BITS-1:2*COORD_BITS];
	assign e_w  = rd_data_q[2*COORD_BITS-1:COORD_BITS];
	assign e_h  = rd_data_q[COORD_BITS-1:0];

	// Index bookkeeping for the scan and the compaction.
	logic [CNT_W-1:0] nxt;
	logic [CNT_W:0] nxt2;
	logic last, last2, room;
	assign nxt   = i_q + 1'b1;
	assign nxt2  = {1'b0, i_q} + 2'd2;
	assign last  = (nxt == count_q);
	assign last2 = (nxt2 == {1'b0, count_q});
	assign room  = (count_q < CNT_MAX);

	// Per entry decisions of the delete scan and the collision test.
	logic match, far, near, hit;
	logic [AW-1:0] lim_x, lim_y;
	logic [COORD_BITS-1:0] hw, hh;
	assign match = (e_cx == x_q) && (e_cy == y_q);
	assign hw    = e_w >> 1;
	assign hh    = e_h >> 1;
	assign lim_x = (AW'(e_w) + AW'(diam_q)) >> 1;
	assign lim_y = (AW'(e_h) + AW'(diam_q)) >> 1;
	assign far   = (AW'(dx_q) > lim_x) || (AW'(dy_q) > lim_y);
	assign near  = (dx_q <= hw) || (dy_q <= hh);
	assign hit   = (sum_q <= SUM_W'(radsq_q));

	// Shared multiplier: radius squared once, then the corner distances.
	logic [MUL_W-1:0] mul_a;
	logic [PROD_W-1:0] mul_p;
	logic [RAD_W-1:0] rad;
	assign rad = RAD_W'(diam_q >> 1);
	always_comb begin
		case (state_q)
			S_SQX:   mul_a = MUL_W'(ex_q);
			S_SQY:   mul_a = MUL_W'(ey_q);
			default: mul_a = MUL_W'(rad);
		endcase
	end
	assign mul_p = mul_a * mul_a;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (opcode)
						OP_ADD:  state_d = S_ADD;
						OP_DEL:  state_d = (count_q == '0) ? S_DONE : S_READ;
						OP_CHK:  state_d = S_PREP;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_PREP:  state_d = (count_q == '0) ? S_DONE : S_READ;
			S_ADD:   state_d = S_DONE;
			S_READ:  state_d = S_EVAL;
			S_EVAL: begin
				if (op_q == OP_DEL) begin
					if (match) begin
						state_d = last ? S_DONE : S_SHIFT_RD;
					end else begin
						state_d = last ? S_DONE : S_READ;
					end
				end else begin
					state_d = S_TEST;
				end
			end
			S_TEST: begin
				if (far) begin
					state_d = last ? S_DONE : S_READ;
				end else if (near) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SQX;
				end
			end
			S_SQX:   state_d = S_SQY;
			S_SQY:   state_d = S_CMPSQ;
			S_CMPSQ: state_d = (hit || last) ? S_DONE : S_READ;
			S_SHIFT_RD: state_d = S_SHIFT_WR;
			S_SHIFT_WR: state_d = last2 ? S_DONE : S_SHIFT_RD;
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Handshake and memory port controls.
	always_comb begin
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wa    = i_q[IDX_W-1:0];
		mem_ra    = i_q[IDX_W-1:0];
		mem_wd    = rd_data_q;
		case (state_q)
			S_IDLE: begin
				in_stall  = 1'b0;
				cfg_ready = 1'b1;
			end
			S_ADD: begin
				mem_we = room;
				mem_wa = count_q[IDX_W-1:0];
				mem_wd = {x_q, y_q, w_q, h_q};
			end
			S_READ: begin
				mem_re = 1'b1;
			end
			S_SHIFT_RD: begin
				mem_re = 1'b1;
				mem_ra = nxt[IDX_W-1:0];
			end
			S_SHIFT_WR: begin
				mem_we = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[mem_ra];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			i_q         <= '0;
			ok_q        <= 1'b0;
			full_q      <= 1'b0;
			op_q        <= OP_ADD;
			diam_q      <= DIAM_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				diam_q <= cfg_diameter;
			end
			// The result register fills out of the done state and empties when taken.
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q   <= opcode;
						i_q    <= '0;
						ok_q   <= (opcode == OP_CHK);
						full_q <= 1'b0;
					end
				end
				S_ADD: begin
					if (room) begin
						count_q <= count_q + 1'b1;
						ok_q    <= 1'b1;
					end else begin
						full_q <= 1'b1;
					end
				end
				S_EVAL: begin
					if (op_q == OP_DEL) begin
						if (match) begin
							ok_q <= 1'b1;
							if (last) begin
								count_q <= count_q - 1'b1;
							end
						end else if (!last) begin
							i_q <= nxt;
						end
					end
				end
				S_TEST: begin
					if (far) begin
						if (!last) begin
							i_q <= nxt;
						end
					end else if (near) begin
						ok_q <= 1'b0;
					end
				end
				S_CMPSQ: begin
					if (hit) begin
						ok_q <= 1'b0;
					end else if (!last) begin
						i_q <= nxt;
					end
				end
				S_SHIFT_WR: begin
					i_q <= nxt;
					if (last2) begin
						count_q <= count_q - 1'b1;
					end
				end
				default: begin
					ok_q <= ok_q;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					x_q <= pos_x;
					y_q <= pos_y;
					w_q <= rect_width;
					h_q <= rect_height;
				end
			end
			S_PREP: begin
				radsq_q <= mul_p;
			end
			S_EVAL: begin
				dx_q <= (x_q >= e_cx) ? (x_q - e_cx) : (e_cx - x_q);
				dy_q <= (y_q >= e_cy) ? (y_q - e_cy) : (e_cy - y_q);
			end
			S_TEST: begin
				ex_q <= dx_q - hw;
				ey_q <= dy_q - hh;
			end
			S_SQX: begin
				acc_q <= mul_p;
			end
			S_SQY: begin
				sum_q <= SUM_W'(acc_q) + SUM_W'(mul_p);
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					success_q        <= ok_q;
					table_full_q     <= full_q;
					obstacle_count_q <= count_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign success        = success_q;
	assign table_full     = table_full_q;
	assign obstacle_count = obstacle_count_q;

	// The stored count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("obstacle count above table depth");

	// An add with room grows the count by exactly one.
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD && room) |=> (count_q == $past(count_q) + 1'b1))
		else $error("add did not grow the count");

	// A new result beat is only raised out of the done state.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside done state");

	// A refused add only happens on a full table.
	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && full_q) |-> (op_q == OP_ADD && count_q == CNT_MAX))
		else $error("table full flag without a full table");

endmodule

FILE: tb/sv/coct_checker.sv
`timescale 1ns / 1ps

module coct_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [1:0]                   opcode,
	input  logic [11:0]                  pos_x,
	input  logic [11:0]                  pos_y,
	input  logic [11:0]                  rect_width,
	input  logic [11:0]                  rect_height,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic                         success,
	input  logic                         table_full,
	input  logic [6:0]                   obstacle_count,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [coct_pkg::DIAM_W-1:0]  cfg_diameter,
	output int                           mismatches,
	output int                           outstanding
);

	import coct_pkg::*;

	localparam int TABLE_DEPTH = 64;

	typedef struct packed {
		logic [11:0] cx;
		logic [11:0] cy;
		logic [11:0] w;
		logic [11:0] h;
	} obstacle_t;

	typedef struct packed {
		logic       success;
		logic       table_full;
		logic [6:0] count;
	} outcome_t;

	// Shadow copy of the obstacle table and the diameter register.
	obstacle_t          obstacles [TABLE_DEPTH];
	int                 obstacle_total;
	logic [DIAM_W-1:0]  diameter;
	outcome_t           pending_outcomes [$];
	int                 result_index;

	initial begin
		mismatches = 0;
		outstanding = 0;
		result_index = 0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH result %0d: %s got %0d expected %0d", result_index, what, got, want);
		mismatches++;
	endtask

	// Circle against rectangle: reject on the bounding box, accept on the
	// straight sides, and fall back to the corner distance otherwise.
	function automatic bit robot_touches(input logic [11:0] x, input logic [11:0] y,
		input obstacle_t r, input logic [DIAM_W-1:0] d);
		longint unsigned xs, ys, cx, cy, w, h, dd, dx, dy, hw, hh, ex, ey, rad;
		xs = x;
		ys = y;
		cx = r.cx;
		cy = r.cy;
		w = r.w;
		h = r.h;
		dd = d;
		dx = (xs >= cx) ? xs - cx : cx - xs;
		dy = (ys >= cy) ? ys - cy : cy - ys;
		hw = w / 2;
		hh = h / 2;
		if (dx > (w + dd) / 2)
			return 1'b0;
		if (dy > (h + dd) / 2)
			return 1'b0;
		if (dx <= hw || dy <= hh)
			return 1'b1;
		ex = dx - hw;
		ey = dy - hh;
		rad = dd / 2;
		return (ex * ex + ey * ey) <= rad * rad;
	endfunction

	// Applies one command to the shadow table and returns the expected beat.
	function automatic outcome_t apply_command(input logic [1:0] op, input logic [11:0] x,
		input logic [11:0] y, input logic [11:0] w, input logic [11:0] h);
		outcome_t o;
		o.success = 1'b0;
		o.table_full = 1'b0;
		case (op)
			OP_ADD: begin
				if (obstacle_total < TABLE_DEPTH) begin
					obstacles[obstacle_total] = '{cx: x, cy: y, w: w, h: h};
					obstacle_total++;
					o.success = 1'b1;
				end else begin
					o.table_full = 1'b1;
				end
			end
			OP_DEL: begin
				for (int i = 0; i < obstacle_total; i++) begin
					if (obstacles[i].cx == x && obstacles[i].cy == y) begin
						for (int j = i; j + 1 < obstacle_total; j++)
							obstacles[j] = obstacles[j + 1];
						obstacle_total--;
						o.success = 1'b1;
						break;
					end
				end
			end
			OP_CHK: begin
				o.success = 1'b1;
				for (int i = 0; i < obstacle_total; i++) begin
					if (robot_touches(x, y, obstacles[i], diameter)) begin
						o.success = 1'b0;
						break;
					end
				end
			end
			default: begin
			end
		endcase
		o.count = obstacle_total[6:0];
		return o;
	endfunction

	// Results are compared before a new beat is predicted, since a result
	// leaving at an edge always belongs to an earlier input beat.
	always @(posedge clk or negedge arst_n) begin : monitor
		outcome_t want;
		if (!arst_n) begin
			obstacle_total = 0;
			diameter = DIAM_RESET;
			pending_outcomes.delete();
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				diameter = cfg_diameter;
			if (out_valid && !out_stall) begin
				if (pending_outcomes.size() == 0) begin
					report_mismatch("unexpected result, count", obstacle_count, -1);
				end else begin
					want = pending_outcomes.pop_front();
					if (success !== want.success)
						report_mismatch("success", success, want.success);
					if (table_full !== want.table_full)
						report_mismatch("table_full", table_full, want.table_full);
					if (obstacle_count !== want.count)
						report_mismatch("obstacle_count", obstacle_count, want.count);
				end
				result_index++;
			end
			if (in_valid && !in_stall)
				pending_outcomes.insert(pending_outcomes.size(),
					apply_command(opcode, pos_x, pos_y, rect_width, rect_height));
			outstanding = pending_outcomes.size();
		end
	end

endmodule

FILE: tb/sv/tb_circle_obstacle_collision_table.sv
`timescale 1ns / 1ps

module tb_circle_obstacle_collision_table;

	import coct_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 190;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 20;

	// Operation mixes used by the random phases.
	typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         opcode = OP_ADD;
	logic [11:0]        pos_x = '0;
	logic [11:0]        pos_y = '0;
	logic [11:0]        rect_width = '0;
	logic [11:0]        rect_height = '0;
	logic               out_valid;
	logic               out_stall = 1'b1;
	logic               success;
	logic               table_full;
	logic [6:0]         obstacle_count;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [DIAM_W-1:0]  cfg_diameter = '0;

	int                 mismatches;
	int                 outstanding;
	int                 idle_cycles = 0;
	bit                 steady = 1'b0;
	bit                 hold_output = 1'b0;
	logic [DIAM_W-1:0]  active_diameter = DIAM_RESET;

	// Obstacles recently sent, used to aim deletes and checks.
	int                 placed_x [$];
	int                 placed_y [$];
	int                 placed_w [$];
	int                 placed_h [$];

	circle_obstacle_collision_table uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.rect_width     (rect_width),
		.rect_height    (rect_height),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.success        (success),
		.table_full     (table_full),
		.obstacle_count (obstacle_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_diameter   (cfg_diameter)
	);

	coct_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.rect_width     (rect_width),
		.rect_height    (rect_height),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.success        (success),
		.table_full     (table_full),
		.obstacle_count (obstacle_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_diameter   (cfg_diameter),
		.mismatches     (mismatches),
		.outstanding    (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int clamp_coord(input int v);
		if (v < 0)
			return 0;
		if (v > 4095)
			return 4095;
		return v;
	endfunction

	// Offers one input beat, holds it until taken, then idles for a while.
	task automatic send_item(input logic [1:0] op, input int x, input int y, input int w,
		input int h);
		int gap;
		in_valid <= 1'b1;
		opcode <= op;
		pos_x <= x[11:0];
		pos_y <= y[11:0];
		rect_width <= w[11:0];
		rect_height <= h[11:0];
		do
			@(posedge clk);
		while (in_stall);
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering beats and waits until every result has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_diameter(input logic [DIAM_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_diameter <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		active_diameter = d;
		@(posedge clk);
	endtask

	function automatic logic [1:0] pick_opcode(input mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return OP_NONE;
		case (mix)
			MIX_FILL:  return (r < 63) ? OP_ADD : (r < 78) ? OP_DEL : OP_CHK;
			MIX_DRAIN: return (r < 18) ? OP_ADD : (r < 63) ? OP_DEL : OP_CHK;
			default:   return (r < 35) ? OP_ADD : (r < 65) ? OP_DEL : OP_CHK;
		endcase
	endfunction

	// Builds one random beat: adds mostly small obstacles, deletes mostly
	// known centers, and checks mostly close to a known obstacle.
	task automatic send_random(input mix_t mix);
		logic [1:0] op;
		int x, y, w, h, k, span;
		op = pick_opcode(mix);
		x = $urandom_range(0, 4095);
		y = $urandom_range(0, 4095);
		w = $urandom_range(0, 4095);
		h = $urandom_range(0, 4095);
		case (op)
			OP_ADD: begin
				if ($urandom_range(0, 99) < 80) begin
					w = $urandom_range(0, 255);
					h = $urandom_range(0, 255);
				end
				if (placed_x.size() > 0 && $urandom_range(0, 99) < 25) begin
					k = $urandom_range(0, placed_x.size() - 1);
					x = placed_x[k];
					y = placed_y[k];
				end
				placed_x.insert(placed_x.size(), x);
				placed_y.insert(placed_y.size(), y);
				placed_w.insert(placed_w.size(), w);
				placed_h.insert(placed_h.size(), h);
				if (placed_x.size() > 80) begin
					void'(placed_x.pop_front());
					void'(placed_y.pop_front());
					void'(placed_w.pop_front());
					void'(placed_h.pop_front());
				end
			end
			OP_DEL: begin
				if (placed_x.size() > 0 && $urandom_range(0, 99) < 75) begin
					k = $urandom_range(0, placed_x.size() - 1);
					x = placed_x[k];
					y = placed_y[k];
					placed_x.delete(k);
					placed_y.delete(k);
					placed_w.delete(k);
					placed_h.delete(k);
				end
			end
			OP_CHK: begin
				if (placed_x.size() > 0 && $urandom_range(0, 99) < 70) begin
					k = $urandom_range(0, placed_x.size() - 1);
					span = placed_w[k] / 2 + active_diameter / 2 + 3;
					x = placed_x[k] + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, span);
					span = placed_h[k] / 2 + active_diameter / 2 + 3;
					y = placed_y[k] + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, span);
					x = clamp_coord(x);
					y = clamp_coord(y);
				end
			end
			default: begin
			end
		endcase
		send_item(op, x, y, w, h);
	endtask

	// Receiver side: random stalls, plus one long hold-off on request.
	initial begin : receiver
		int run, gap;
		forever begin
			if (hold_output) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end
			run = $urandom_range(1, 20);
			out_stall <= 1'b0;
			repeat (run) @(posedge clk);
			gap = steady ? 0 : pick_gap();
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Ends the run when no beat moves on any channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_circle_obstacle_collision_table failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic [DIAM_W-1:0] phase_diameter [PHASES];
		mix_t phase_mix [PHASES];
		phase_diameter = '{DIAM_RESET, 12'd0, 12'd4095, 12'd1, 12'd0, 12'd0};
		phase_diameter[4] = $urandom_range(2, 300);
		phase_diameter[5] = $urandom_range(301, 4094);
		phase_mix = '{MIX_FILL, MIX_EVEN, MIX_FILL, MIX_EVEN, MIX_DRAIN, MIX_EVEN};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset diameter: empty table, unused opcode,
		// field extremes, the side and corner boundaries, repeated centers.
		send_item(OP_CHK, 100, 100, 0, 0);
		send_item(OP_DEL, 5, 5, 0, 0);
		send_item(OP_NONE, 4095, 4095, 4095, 4095);
		send_item(OP_ADD, 0, 0, 0, 0);
		send_item(OP_ADD, 4095, 4095, 4095, 4095);
		send_item(OP_ADD, 1000, 1000, 100, 60);
		send_item(OP_ADD, 1000, 1000, 10, 11);
		send_item(OP_CHK, 1060, 1000, 4095, 4095);
		send_item(OP_CHK, 1061, 1000, 0, 0);
		send_item(OP_CHK, 1057, 1037, 0, 0);
		send_item(OP_CHK, 1058, 1038, 0, 0);
		send_item(OP_CHK, 2000, 2000, 0, 0);
		send_item(OP_CHK, 0, 0, 0, 0);
		send_item(OP_DEL, 1000, 1000, 4095, 4095);
		send_item(OP_CHK, 1058, 1038, 0, 0);
		send_item(OP_DEL, 1000, 1000, 0, 0);
		send_item(OP_DEL, 1000, 1000, 0, 0);
		send_item(OP_NONE, 0, 0, 0, 0);
		send_item(OP_CHK, 4095, 0, 0, 0);
		send_item(OP_DEL, 0, 0, 0, 0);
		send_item(OP_DEL, 4095, 4095, 0, 0);
		send_item(OP_CHK, 2048, 2048, 0, 0);
		wait_idle();

		// Random phases, each with its own diameter and operation mix.
		for (int p = 0; p < PHASES; p++) begin
			write_diameter(phase_diameter[p]);
			steady = (p == 1);
			if (p == 2)
				hold_output = 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_random(phase_mix[p]);
			wait_idle();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("tb_circle_obstacle_collision_table passed");
		else
			$display("tb_circle_obstacle_collision_table failed");
		$finish;
	end

endmodule

FILE: filelist.f
src/coct_pkg.sv
src/circle_obstacle_collision_table.sv
tb/sv/coct_checker.sv
tb/sv/tb_circle_obstacle_collision_table.sv
